// File: rtl/core/split_l1_cache_lru_model_defines.svh
// Assertion macros for the split L1 cache model checker.
`ifndef SPLIT_L1_CACHE_LRU_MODEL_DEFINES_SVH
`define SPLIT_L1_CACHE_LRU_MODEL_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define SLC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slc check failed");

// Check that cons holds in the cycle after ante.
`define SLC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slc check failed");

`endif

// File: rtl/core/slc_pkg.sv
// Shared codes, widths and types of the split L1 cache model.
package slc_pkg;

  localparam int OP_W        = 3;
  localparam int ADDR_W      = 32;
  localparam int REQ_W       = 2;
  localparam int CNT_W       = 32;
  localparam int N_CNT       = 6;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 232;
  localparam int OUT_PAD_W   = OUT_TDATA_W - (1 + REQ_W + ADDR_W + N_CNT * CNT_W);

  // Operation codes
  localparam logic [OP_W-1:0] OP_DATA_READ  = 3'd0;
  localparam logic [OP_W-1:0] OP_DATA_WRITE = 3'd1;
  localparam logic [OP_W-1:0] OP_INSTR_READ = 3'd2;
  localparam logic [OP_W-1:0] OP_EVICT      = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd4;
  localparam logic [OP_W-1:0] OP_REPORT     = 3'd5;

  // Next level request codes
  localparam logic [REQ_W-1:0] REQ_NONE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RFO  = 2'd2;

  // Event counter slots
  localparam int CNT_READS       = 0;
  localparam int CNT_WRITES      = 1;
  localparam int CNT_READ_HITS   = 2;
  localparam int CNT_READ_MISSES = 3;
  localparam int CNT_WRITE_HITS  = 4;
  localparam int CNT_WRITE_MISS  = 5;

  typedef logic [CNT_W-1:0] count_t;

endpackage

// File: rtl/core/slc_ram.sv
// Generic simple dual-port RAM with registered read.
module slc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one row, read one row; read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/slc_set_lru.sv
// Lookup, victim choice and age rank update of one cache set row.
module slc_set_lru #(
  parameter int WAYS  = 4,
  parameter int TAG_W = 12
) (
  input  logic [WAYS*(TAG_W+(WAYS > 1 ? $clog2(WAYS) : 1)+1)-1:0] row_i,
  input  logic [TAG_W-1:0]                                         tag_i,
  output logic                                                     hit_o,
  output logic [WAYS*(TAG_W+(WAYS > 1 ? $clog2(WAYS) : 1)+1)-1:0] row_o
);

  localparam int RW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int PW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ENT_W = TAG_W + RW + 1;

  logic [WAYS-1:0]  vld;
  logic [WAYS-1:0]  match;
  logic [TAG_W-1:0] tags [WAYS];
  logic [RW-1:0]    rank [WAYS];
  logic [PW-1:0]    hit_way;
  logic [PW-1:0]    free_way;
  logic [PW-1:0]    lru_way;
  logic [PW-1:0]    pick;
  logic [RW:0]      old_rank;

  // Split the row into ways and compare tags
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      tags[w]  = row_i[w*ENT_W +: TAG_W];
      rank[w]  = row_i[w*ENT_W + TAG_W +: RW];
      vld[w]   = row_i[w*ENT_W + TAG_W + RW];
      match[w] = vld[w] && (tags[w] == tag_i);
    end
  end

  // Pick the way: first hit, else first free way, else the oldest
  always_comb begin
    hit_way  = '0;
    free_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = PW'(w);
      end
      if (!vld[w]) begin
        free_way = PW'(w);
      end
    end
    lru_way = '0;
    for (int w = 1; w < WAYS; w++) begin
      if (rank[w] > rank[lru_way]) begin
        lru_way = PW'(w);
      end
    end
    priority if (|match) begin
      pick = hit_way;
    end else if (!(&vld)) begin
      pick = free_way;
    end else begin
      pick = lru_way;
    end
  end

  assign hit_o    = |match;
  assign old_rank = vld[pick] ? {1'b0, rank[pick]} : (RW+1)'(WAYS);

  // Age the younger valid ways and make the picked way the newest
  always_comb begin
    row_o = row_i;
    for (int w = 0; w < WAYS; w++) begin
      if (PW'(w) == pick) begin
        row_o[w*ENT_W +: ENT_W] = {1'b1, {RW{1'b0}}, tag_i};
      end else if (vld[w] && ({1'b0, rank[w]} < old_rank)) begin
        row_o[w*ENT_W + TAG_W +: RW] = rank[w] + RW'(1);
      end
    end
  end

endmodule

// File: rtl/core/split_l1_cache_lru_model.sv
// Top level of the tag-only split L1 cache model with LRU replacement.
// Each accepted transaction first reads the set row from the data and
// instruction tag RAMs, then picks the way, writes the row back and loads the
// result register. A new transaction is taken in the cycle after the
// write-back, so rows never overlap in flight. The result is held in an output
// register; while it waits to be taken, the next transaction is read but its
// update waits for the result slot. After reset and after every clear
// operation a clearing pass writes empty rows into both RAMs, one set per
// cycle, over all SET_COUNT sets; no transaction is taken meanwhile. SET_COUNT
// and LINE_BYTES must be powers of two; the block does not enforce it. Result
// tdata also carries the six event counters as they stand after the operation.
module split_l1_cache_lru_model #(
  parameter int SET_COUNT    = 16384,
  parameter int LINE_BYTES   = 64,
  parameter int DATA_WAYS    = 4,
  parameter int INSTR_WAYS   = 2,
  parameter int ADDRESS_BITS = 32
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [2:0] op, [34:3] address, [39:35] zero
  input  logic [slc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [0] hit, [2:1] next_level_request, [34:3] request_address,
  // [66:35] reads_seen, [98:67] writes_seen, [130:99] read_hits_seen,
  // [162:131] read_misses_seen, [194:163] write_hits_seen,
  // [226:195] write_misses_seen, [231:227] zero
  output logic [slc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  localparam int OFF_BITS = $clog2(LINE_BYTES);
  localparam int SET_BITS = $clog2(SET_COUNT);
  localparam int IDX_W    = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int AW_EFF   = (ADDRESS_BITS < slc_pkg::ADDR_W) ? ADDRESS_BITS : slc_pkg::ADDR_W;
  localparam int TAG_RAW  = AW_EFF - OFF_BITS - SET_BITS;
  localparam int TAG_W    = (TAG_RAW > 0) ? TAG_RAW : 1;
  localparam int D_RW     = (DATA_WAYS > 1) ? $clog2(DATA_WAYS) : 1;
  localparam int I_RW     = (INSTR_WAYS > 1) ? $clog2(INSTR_WAYS) : 1;
  localparam int D_ROW_W  = DATA_WAYS * (TAG_W + D_RW + 1);
  localparam int I_ROW_W  = INSTR_WAYS * (TAG_W + I_RW + 1);

  localparam logic [IDX_W-1:0] LAST_SET = IDX_W'(SET_COUNT - 1);
  localparam logic [slc_pkg::ADDR_W-1:0] ADDR_MASK = (ADDRESS_BITS >= slc_pkg::ADDR_W) ?
      {slc_pkg::ADDR_W{1'b1}} : slc_pkg::ADDR_W'((64'd1 << ADDRESS_BITS) - 64'd1);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_LOOKUP = 2'd2;

  logic [1:0]                   state_q, state_d;
  logic [IDX_W-1:0]             clr_idx_q, clr_idx_d;
  logic [slc_pkg::OP_W-1:0]     op_q;
  logic [slc_pkg::ADDR_W-1:0]   addr_q;
  logic                         m_valid_q;
  logic                         out_hit_q;
  logic [slc_pkg::REQ_W-1:0]    out_req_q;
  logic [slc_pkg::ADDR_W-1:0]   out_addr_q;
  slc_pkg::count_t              cnt_q [slc_pkg::N_CNT];

  logic [slc_pkg::ADDR_W-1:0]   in_addr;
  logic [slc_pkg::ADDR_W-1:0]   in_line;
  logic [IDX_W-1:0]             in_set;
  logic [slc_pkg::ADDR_W-1:0]   cur_line;
  logic [IDX_W-1:0]             cur_set;
  logic [TAG_W-1:0]             cur_tag;
  logic                         in_acc;
  logic                         out_free;
  logic                         done;
  logic                         clearing;
  logic                         is_data;
  logic                         is_instr;
  logic                         is_read;
  logic                         acc_hit;
  logic [slc_pkg::REQ_W-1:0]    req_d;

  logic [D_ROW_W-1:0] d_rdata, d_wdata, d_row_new;
  logic [I_ROW_W-1:0] i_rdata, i_wdata, i_row_new;
  logic               d_we, i_we, d_hit, i_hit;
  logic [IDX_W-1:0]   waddr;

  // Decode the incoming transaction
  assign in_addr  = s_axis_tdata[slc_pkg::OP_W +: slc_pkg::ADDR_W] & ADDR_MASK;
  assign in_line  = in_addr >> OFF_BITS;
  assign in_set   = IDX_W'(in_line) & LAST_SET;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc   = s_axis_tvalid && s_axis_tready;

  // Split the held address into set and tag
  assign cur_line = addr_q >> OFF_BITS;
  assign cur_set  = IDX_W'(cur_line) & LAST_SET;
  assign cur_tag  = TAG_W'(cur_line >> SET_BITS);

  assign out_free = !m_valid_q || m_axis_tready;
  assign done     = (state_q == ST_LOOKUP) && out_free;
  assign clearing = (state_q == ST_CLEAR);
  assign is_data  = (op_q == slc_pkg::OP_DATA_READ) || (op_q == slc_pkg::OP_DATA_WRITE);
  assign is_instr = (op_q == slc_pkg::OP_INSTR_READ);
  assign is_read  = (op_q == slc_pkg::OP_DATA_READ) || (op_q == slc_pkg::OP_INSTR_READ);
  assign acc_hit  = is_instr ? i_hit : d_hit;

  // Set update units
  slc_set_lru #(.WAYS(DATA_WAYS), .TAG_W(TAG_W)) u_data_set (
    .row_i (d_rdata),
    .tag_i (cur_tag),
    .hit_o (d_hit),
    .row_o (d_row_new)
  );

  slc_set_lru #(.WAYS(INSTR_WAYS), .TAG_W(TAG_W)) u_instr_set (
    .row_i (i_rdata),
    .tag_i (cur_tag),
    .hit_o (i_hit),
    .row_o (i_row_new)
  );

  // Write back the touched row, or an empty row during the clearing pass
  assign d_we    = clearing || (done && is_data);
  assign i_we    = clearing || (done && is_instr);
  assign waddr   = clearing ? clr_idx_q : cur_set;
  assign d_wdata = clearing ? '0 : d_row_new;
  assign i_wdata = clearing ? '0 : i_row_new;

  slc_ram #(.WIDTH(D_ROW_W), .DEPTH(SET_COUNT)) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .waddr_i (waddr),
    .wdata_i (d_wdata),
    .re_i    (in_acc),
    .raddr_i (in_set),
    .rdata_o (d_rdata)
  );

  slc_ram #(.WIDTH(I_ROW_W), .DEPTH(SET_COUNT)) u_instr_ram (
    .clk_i   (clk_i),
    .we_i    (i_we),
    .waddr_i (waddr),
    .wdata_i (i_wdata),
    .re_i    (in_acc),
    .raddr_i (in_set),
    .rdata_o (i_rdata)
  );

  // Next state and clearing pointer
  always_comb begin
    state_d   = state_q;
    clr_idx_d = clr_idx_q;
    unique case (state_q)
      ST_CLEAR: begin
        clr_idx_d = clr_idx_q + IDX_W'(1);
        if (clr_idx_q == LAST_SET) begin
          clr_idx_d = '0;
          state_d   = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (done) begin
          state_d = (op_q == slc_pkg::OP_CLEAR) ? ST_CLEAR : ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_idx_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_idx_q <= clr_idx_d;
    end
  end

  // Hold the accepted transaction
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q   <= s_axis_tdata[slc_pkg::OP_W-1:0];
      addr_q <= in_addr;
    end
  end

  // Next level request for a miss
  always_comb begin
    req_d = slc_pkg::REQ_NONE;
    if (!acc_hit) begin
      if (is_read) begin
        req_d = slc_pkg::REQ_READ;
      end else if (op_q == slc_pkg::OP_DATA_WRITE) begin
        req_d = slc_pkg::REQ_RFO;
      end
    end
  end

  // Load the result payload
  always_ff @(posedge clk_i) begin
    if (done) begin
      out_hit_q  <= (is_data || is_instr) && acc_hit;
      out_req_q  <= req_d;
      out_addr_q <= (req_d != slc_pkg::REQ_NONE) ? addr_q : '0;
    end
  end

  // Result valid and event counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
      for (int i = 0; i < slc_pkg::N_CNT; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      if (done) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (done) begin
        unique case (op_q)
          slc_pkg::OP_DATA_READ, slc_pkg::OP_INSTR_READ: begin
            cnt_q[slc_pkg::CNT_READS] <= cnt_q[slc_pkg::CNT_READS] + 1'b1;
            if (acc_hit) begin
              cnt_q[slc_pkg::CNT_READ_HITS] <= cnt_q[slc_pkg::CNT_READ_HITS] + 1'b1;
            end else begin
              cnt_q[slc_pkg::CNT_READ_MISSES] <= cnt_q[slc_pkg::CNT_READ_MISSES] + 1'b1;
            end
          end
          slc_pkg::OP_DATA_WRITE: begin
            cnt_q[slc_pkg::CNT_WRITES] <= cnt_q[slc_pkg::CNT_WRITES] + 1'b1;
            if (acc_hit) begin
              cnt_q[slc_pkg::CNT_WRITE_HITS] <= cnt_q[slc_pkg::CNT_WRITE_HITS] + 1'b1;
            end else begin
              cnt_q[slc_pkg::CNT_WRITE_MISS] <= cnt_q[slc_pkg::CNT_WRITE_MISS] + 1'b1;
            end
          end
          slc_pkg::OP_CLEAR: begin
            for (int i = 0; i < slc_pkg::N_CNT; i++) begin
              cnt_q[i] <= '0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{slc_pkg::OUT_PAD_W{1'b0}},
                          cnt_q[slc_pkg::CNT_WRITE_MISS],
                          cnt_q[slc_pkg::CNT_WRITE_HITS],
                          cnt_q[slc_pkg::CNT_READ_MISSES],
                          cnt_q[slc_pkg::CNT_READ_HITS],
                          cnt_q[slc_pkg::CNT_WRITES],
                          cnt_q[slc_pkg::CNT_READS],
                          out_addr_q, out_req_q, out_hit_q};

endmodule

// File: rtl/core/slc_checker.sv
// Port-level checks of the split L1 cache model and their bind.
`include "split_l1_cache_lru_model_defines.svh"

module slc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [slc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  logic                       res_hit;
  logic [slc_pkg::REQ_W-1:0]  res_req;
  logic [slc_pkg::ADDR_W-1:0] res_addr;
  slc_pkg::count_t            reads, writes, rhits, rmiss, whits, wmiss;

  assign res_hit  = m_axis_tdata[0];
  assign res_req  = m_axis_tdata[2:1];
  assign res_addr = m_axis_tdata[34:3];
  assign reads    = m_axis_tdata[66:35];
  assign writes   = m_axis_tdata[98:67];
  assign rhits    = m_axis_tdata[130:99];
  assign rmiss    = m_axis_tdata[162:131];
  assign whits    = m_axis_tdata[194:163];
  assign wmiss    = m_axis_tdata[226:195];

  // A stalled result holds
  `SLC_ASSERT_NEXT(a_res_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata))
  // A hit never asks the next level
  `SLC_ASSERT_SAME(a_hit_no_req, clk_i, rst_ni, m_axis_tvalid && res_hit,
                   res_req == slc_pkg::REQ_NONE)
  // No request means no request address
  `SLC_ASSERT_SAME(a_req_addr, clk_i, rst_ni, m_axis_tvalid && (res_req == slc_pkg::REQ_NONE),
                   res_addr == '0)
  // Hits and misses add up to the access counts, and the request code is a known one
  `SLC_ASSERT_SAME(a_cnt_sum, clk_i, rst_ni, m_axis_tvalid,
                   (reads == slc_pkg::count_t'(rhits + rmiss)) &&
                   (writes == slc_pkg::count_t'(whits + wmiss)) &&
                   (res_req <= slc_pkg::REQ_RFO))
  // Only one transaction is in flight: input closes right after an accept
  `SLC_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, s_axis_tvalid && s_axis_tready,
                   !s_axis_tready)

endmodule

bind split_l1_cache_lru_model slc_checker u_slc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: test/split_l1_cache_lru_model_test.sv
// Self-checking stream testbench for the split L1 cache tag model with LRU replacement.
module split_l1_cache_lru_model_test;

  localparam int SET_COUNT    = 16384;
  localparam int LINE_BYTES   = 64;
  localparam int DATA_WAYS    = 4;
  localparam int INSTR_WAYS   = 2;
  localparam int ADDRESS_BITS = 32;

  localparam int OFFSET_BITS = $clog2(LINE_BYTES);
  localparam int SET_BITS    = $clog2(SET_COUNT);
  localparam int TAG_BITS    = ADDRESS_BITS - OFFSET_BITS - SET_BITS;
  localparam int DC_ROWS     = SET_COUNT * DATA_WAYS;
  localparam int IC_ROWS     = SET_COUNT * INSTR_WAYS;

  // Unused op codes: the block treats them as no-ops
  localparam logic [slc_pkg::OP_W-1:0] OP_SPARE6 = 3'd6;
  localparam logic [slc_pkg::OP_W-1:0] OP_SPARE7 = 3'd7;

  localparam int DIRECTED_N   = 23;
  localparam int ITEM_COUNT   = 1800;
  localparam int MAX_CLEARS   = 6;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 1500000;
  localparam int PRINT_LIMIT  = 40;

  typedef enum int {RX_OPEN, RX_COIN, RX_LIGHT, RX_HEAVY} rx_mode_e;

  // One stimulus row; typed results apply only where typed_exp is set
  typedef struct packed {
    logic [slc_pkg::OP_W-1:0]   op;
    logic [slc_pkg::ADDR_W-1:0] addr;
    logic                       typed_exp;
    logic                       hit;
    logic [slc_pkg::REQ_W-1:0]  req;
    logic [slc_pkg::ADDR_W-1:0] req_addr;
  } stim_row_t;

  // Result laid out as on m_axis_tdata, highest bits first
  typedef struct packed {
    logic [slc_pkg::OUT_PAD_W-1:0] pad;
    slc_pkg::count_t               write_misses;
    slc_pkg::count_t               write_hits;
    slc_pkg::count_t               read_misses;
    slc_pkg::count_t               read_hits;
    slc_pkg::count_t               writes;
    slc_pkg::count_t               reads;
    logic [slc_pkg::ADDR_W-1:0]    req_addr;
    logic [slc_pkg::REQ_W-1:0]     req;
    logic                          hit;
  } result_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [slc_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [slc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  // Cache predictor state
  logic [TAG_BITS-1:0] dc_tag   [DC_ROWS];
  bit                  dc_valid [DC_ROWS];
  bit   [1:0]          dc_rank  [DC_ROWS];
  logic [TAG_BITS-1:0] ic_tag   [IC_ROWS];
  bit                  ic_valid [IC_ROWS];
  bit                  ic_rank  [IC_ROWS];
  slc_pkg::count_t     event_count [slc_pkg::N_CNT];

  logic [SET_BITS-1:0] hot_sets [6];
  stim_row_t           directed_rows [DIRECTED_N];
  stim_row_t           stim_q [$];
  result_t             expected_q [$];
  int unsigned         error_count;
  int unsigned         cycle_count;

  split_l1_cache_lru_model #(
    .SET_COUNT   (SET_COUNT),
    .LINE_BYTES  (LINE_BYTES),
    .DATA_WAYS   (DATA_WAYS),
    .INSTR_WAYS  (INSTR_WAYS),
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Look up one set, refresh recency, fill or replace on a miss; return hit
  function automatic bit touch_line(input bit instr, input logic [SET_BITS-1:0] set_idx,
                                    input logic [TAG_BITS-1:0] tag);
    int ways, base, pick, prior, w;
    bit found;
    logic [TAG_BITS-1:0] row_tag   [DATA_WAYS];
    bit                  row_valid [DATA_WAYS];
    logic [3:0]          row_rank  [DATA_WAYS];
    ways = instr ? INSTR_WAYS : DATA_WAYS;
    base = int'(set_idx) * ways;
    for (w = 0; w < ways; w++) begin
      row_tag[w]   = instr ? ic_tag[base + w] : dc_tag[base + w];
      row_valid[w] = instr ? ic_valid[base + w] : dc_valid[base + w];
      row_rank[w]  = instr ? 4'(ic_rank[base + w]) : 4'(dc_rank[base + w]);
    end
    found = 1'b0;
    pick = ways;
    for (w = 0; w < ways; w++) begin
      if (!found && row_valid[w] && row_tag[w] == tag) begin
        pick = w;
        found = 1'b1;
      end
    end
    // Miss: lowest free way first, else the oldest way
    if (!found) begin
      for (w = ways - 1; w >= 0; w--) begin
        if (!row_valid[w]) pick = w;
      end
      if (pick == ways) begin
        pick = 0;
        for (w = 1; w < ways; w++) begin
          if (row_rank[w] > row_rank[pick]) pick = w;
        end
      end
    end
    prior = row_valid[pick] ? int'(row_rank[pick]) : ways;
    for (w = 0; w < ways; w++) begin
      if (w != pick && row_valid[w] && int'(row_rank[w]) < prior)
        row_rank[w] = row_rank[w] + 4'd1;
    end
    row_tag[pick]   = tag;
    row_valid[pick] = 1'b1;
    row_rank[pick]  = '0;
    for (w = 0; w < ways; w++) begin
      if (instr) begin
        ic_tag[base + w]   = row_tag[w];
        ic_valid[base + w] = row_valid[w];
        ic_rank[base + w]  = row_rank[w][0];
      end else begin
        dc_tag[base + w]   = row_tag[w];
        dc_valid[base + w] = row_valid[w];
        dc_rank[base + w]  = row_rank[w][1:0];
      end
    end
    return found;
  endfunction

  // Advance the predictor by one transaction and return the result it implies
  function automatic result_t predict_cache_op(input logic [slc_pkg::OP_W-1:0] op,
                                               input logic [slc_pkg::ADDR_W-1:0] addr);
    result_t r;
    bit h;
    int i;
    r = '0;
    case (op)
      slc_pkg::OP_DATA_READ, slc_pkg::OP_INSTR_READ: begin
        event_count[slc_pkg::CNT_READS] += 1;
        h = touch_line(op == slc_pkg::OP_INSTR_READ, addr[OFFSET_BITS +: SET_BITS],
                       addr[ADDRESS_BITS-1 -: TAG_BITS]);
        if (h) begin
          event_count[slc_pkg::CNT_READ_HITS] += 1;
          r.hit = 1'b1;
        end else begin
          event_count[slc_pkg::CNT_READ_MISSES] += 1;
          r.req = slc_pkg::REQ_READ;
          r.req_addr = addr;
        end
      end
      slc_pkg::OP_DATA_WRITE: begin
        event_count[slc_pkg::CNT_WRITES] += 1;
        h = touch_line(1'b0, addr[OFFSET_BITS +: SET_BITS], addr[ADDRESS_BITS-1 -: TAG_BITS]);
        if (h) begin
          event_count[slc_pkg::CNT_WRITE_HITS] += 1;
          r.hit = 1'b1;
        end else begin
          event_count[slc_pkg::CNT_WRITE_MISS] += 1;
          r.req = slc_pkg::REQ_RFO;
          r.req_addr = addr;
        end
      end
      slc_pkg::OP_CLEAR: begin
        for (i = 0; i < DC_ROWS; i++) begin
          dc_valid[i] = 1'b0;
          dc_rank[i]  = '0;
        end
        for (i = 0; i < IC_ROWS; i++) begin
          ic_valid[i] = 1'b0;
          ic_rank[i]  = 1'b0;
        end
        for (i = 0; i < slc_pkg::N_CNT; i++) event_count[i] = '0;
      end
      default: ;
    endcase
    r.reads        = event_count[slc_pkg::CNT_READS];
    r.writes       = event_count[slc_pkg::CNT_WRITES];
    r.read_hits    = event_count[slc_pkg::CNT_READ_HITS];
    r.read_misses  = event_count[slc_pkg::CNT_READ_MISSES];
    r.write_hits   = event_count[slc_pkg::CNT_WRITE_HITS];
    r.write_misses = event_count[slc_pkg::CNT_WRITE_MISS];
    return r;
  endfunction

  // Mostly a few hot sets and tags so that hits and evictions happen; else any address
  function automatic logic [slc_pkg::ADDR_W-1:0] access_address();
    logic [TAG_BITS-1:0]    tag;
    logic [OFFSET_BITS-1:0] offset;
    if ($urandom_range(0, 9) < 3) return $urandom();
    if ($urandom_range(0, 3) == 0) tag = {TAG_BITS{1'b1}} - TAG_BITS'($urandom_range(0, 1));
    else tag = TAG_BITS'($urandom_range(0, 5));
    offset = OFFSET_BITS'($urandom());
    return {tag, hot_sets[$urandom_range(0, 5)], offset};
  endfunction

  task automatic report_mismatch(input string what, input logic [slc_pkg::ADDR_W-1:0] got,
                                 input logic [slc_pkg::ADDR_W-1:0] want);
    error_count++;
    if (error_count <= PRINT_LIMIT)
      $display("ERROR cycle %0d: %s got 0x%h expected 0x%h", cycle_count, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [slc_pkg::ADDR_W-1:0] got,
                             input logic [slc_pkg::ADDR_W-1:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Count cycles and stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Stall the result side on a pattern that changes mode now and then
  initial begin
    rx_mode_e    mode;
    int unsigned left;
    m_axis_tready <= 1'b0;
    mode = RX_OPEN;
    left = 0;
    forever begin
      @(posedge clk_i);
      if (left == 0) begin
        mode = rx_mode_e'($urandom_range(0, 3));
        left = $urandom_range(20, 300);
      end
      left--;
      case (mode)
        RX_OPEN:  m_axis_tready <= 1'b1;
        RX_COIN:  m_axis_tready <= 1'($urandom_range(0, 1));
        RX_LIGHT: m_axis_tready <= ($urandom_range(0, 7) != 0);
        default:  m_axis_tready <= ($urandom_range(0, 5) == 0);
      endcase
    end
  end

  // Compare each accepted result transaction with the oldest expectation
  always @(posedge clk_i) begin
    result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata);
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result, request_address", got.req_addr, '0);
      end else begin
        want = expected_q.pop_front();
        check_field("hit", 32'(got.hit), 32'(want.hit));
        check_field("next_level_request", 32'(got.req), 32'(want.req));
        check_field("request_address", got.req_addr, want.req_addr);
        check_field("reads_seen", got.reads, want.reads);
        check_field("writes_seen", got.writes, want.writes);
        check_field("read_hits_seen", got.read_hits, want.read_hits);
        check_field("read_misses_seen", got.read_misses, want.read_misses);
        check_field("write_hits_seen", got.write_hits, want.write_hits);
        check_field("write_misses_seen", got.write_misses, want.write_misses);
      end
    end
  end

  initial begin
    stim_row_t   row;
    result_t     want;
    int unsigned i, pick, clears_left, sent, gap_left, burst_left;
    bit          took;

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    error_count = 0;
    for (i = 0; i < slc_pkg::N_CNT; i++) event_count[i] = '0;

    hot_sets[0] = '0;
    hot_sets[1] = {SET_BITS{1'b1}};
    for (i = 2; i < 6; i++) hot_sets[i] = SET_BITS'($urandom());

    // Directed rows: op, address, typed, hit, request, request address
    directed_rows[0]  = '{slc_pkg::OP_DATA_READ,  32'h0000_0000, 1'b1, 1'b0,
                          slc_pkg::REQ_READ, 32'h0000_0000};
    directed_rows[1]  = '{slc_pkg::OP_DATA_READ,  32'h0000_003F, 1'b1, 1'b1,
                          slc_pkg::REQ_NONE, 32'h0};
    directed_rows[2]  = '{slc_pkg::OP_DATA_WRITE, 32'hFFFF_FFFF, 1'b1, 1'b0,
                          slc_pkg::REQ_RFO,  32'hFFFF_FFFF};
    directed_rows[3]  = '{slc_pkg::OP_DATA_WRITE, 32'hFFFF_FFC0, 1'b1, 1'b1,
                          slc_pkg::REQ_NONE, 32'h0};
    directed_rows[4]  = '{slc_pkg::OP_DATA_READ,  32'hFFFF_FFC0, 1'b1, 1'b1,
                          slc_pkg::REQ_NONE, 32'h0};
    directed_rows[5]  = '{slc_pkg::OP_INSTR_READ, 32'h0000_0000, 1'b1, 1'b0,
                          slc_pkg::REQ_READ, 32'h0000_0000};
    // Fill and overflow set 0 of the two-way instruction side
    directed_rows[6]  = '{slc_pkg::OP_INSTR_READ, 32'h0010_0000, 1'b0, 1'b0,
                          slc_pkg::REQ_NONE, 32'h0};
    directed_rows[7]  = '{slc_pkg::OP_INSTR_READ, 32'h0000_0010, 1'b0, 1'b0,
                          slc_pkg::REQ_NONE, 32'h0};
    directed_rows[8]  = '{slc_pkg::OP_INSTR_READ, 32'h0020_0000, 1'b0, 1'b0,
                          slc_pkg::REQ_NONE, 32'h0};
    directed_rows[9]  = '{slc_pkg::OP_INSTR_READ, 32'h0010_0000, 1'b0, 1'b0,
                          slc_pkg::REQ_NONE, 32'h0};
    // Fill set 0 of the data side, refresh the first line, then force a replacement
    directed_rows[10] = '{slc_pkg::OP_DATA_READ,  32'h0010_0000, 1'b0, 1'b0,
                          slc_pkg::REQ_NONE, 32'h0};
    directed_rows[11] = '{slc_pkg::OP_DATA_READ,  32'h0020_0000, 1'b0, 1'b0,
                          slc_pkg::REQ_NONE, 32'h0};
    directed_rows[12] = '{slc_pkg::OP_DATA_READ,  32'h0030_0000, 1'b0, 1'b0,
                          slc_pkg::REQ_NONE, 32'h0};
    directed_rows[13] = '{slc_pkg::OP_DATA_WRITE, 32'h0000_0000, 1'b0, 1'b0,
                          slc_pkg::REQ_NONE, 32'h0};
    directed_rows[14] = '{slc_pkg::OP_DATA_READ,  32'h0040_0000, 1'b0, 1'b0,
                          slc_pkg::REQ_NONE, 32'h0};
    directed_rows[15] = '{slc_pkg::OP_DATA_READ,  32'h0010_0000, 1'b0, 1'b0,
                          slc_pkg::REQ_NONE, 32'h0};
    // Non-access ops leave the caches alone and return no request
    directed_rows[16] = '{slc_pkg::OP_EVICT,      32'hFFFF_FFFF, 1'b1, 1'b0,
                          slc_pkg::REQ_NONE, 32'h0};
    directed_rows[17] = '{slc_pkg::OP_REPORT,     32'hFFFF_FFFF, 1'b1, 1'b0,
                          slc_pkg::REQ_NONE, 32'h0};
    directed_rows[18] = '{OP_SPARE6,              32'h0000_0000, 1'b1, 1'b0,
                          slc_pkg::REQ_NONE, 32'h0};
    directed_rows[19] = '{OP_SPARE7,              32'hFFFF_FFFF, 1'b1, 1'b0,
                          slc_pkg::REQ_NONE, 32'h0};
    // Clear empties both caches and the counters
    directed_rows[20] = '{slc_pkg::OP_CLEAR,      32'hFFFF_FFFF, 1'b1, 1'b0,
                          slc_pkg::REQ_NONE, 32'h0};
    directed_rows[21] = '{slc_pkg::OP_DATA_READ,  32'h0000_0000, 1'b1, 1'b0,
                          slc_pkg::REQ_READ, 32'h0000_0000};
    directed_rows[22] = '{slc_pkg::OP_REPORT,     32'h0000_0000, 1'b1, 1'b0,
                          slc_pkg::REQ_NONE, 32'h0};
    for (i = 0; i < DIRECTED_N; i++) stim_q.push_back(directed_rows[i]);

    // Random part: mostly accesses to hot sets, some no-ops and a few clears
    clears_left = MAX_CLEARS;
    while (stim_q.size() < ITEM_COUNT) begin
      row = '0;
      row.addr = $urandom();
      pick = $urandom_range(0, 99);
      if (pick < 35) row.op = slc_pkg::OP_DATA_READ;
      else if (pick < 60) row.op = slc_pkg::OP_DATA_WRITE;
      else if (pick < 85) row.op = slc_pkg::OP_INSTR_READ;
      else if (pick < 88) row.op = slc_pkg::OP_EVICT;
      else if (pick < 91) row.op = slc_pkg::OP_REPORT;
      else if (pick < 94) row.op = OP_SPARE6;
      else if (pick < 97) row.op = OP_SPARE7;
      else if (clears_left != 0 && $urandom_range(0, 9) == 0) begin
        row.op = slc_pkg::OP_CLEAR;
        clears_left--;
      end else row.op = slc_pkg::OP_DATA_READ;
      if (row.op == slc_pkg::OP_DATA_READ || row.op == slc_pkg::OP_DATA_WRITE ||
          row.op == slc_pkg::OP_INSTR_READ) begin
        row.addr = access_address();
      end
      stim_q.push_back(row);
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Send in bursts with random gaps; predict each accepted transaction
    sent = 0;
    gap_left = 0;
    burst_left = $urandom_range(1, 50);
    while (sent < stim_q.size()) begin
      @(posedge clk_i);
      took = s_axis_tvalid && s_axis_tready;
      if (took) begin
        row = stim_q[sent];
        want = predict_cache_op(row.op, row.addr);
        if (row.typed_exp) begin
          want.hit = row.hit;
          want.req = row.req;
          want.req_addr = row.req_addr;
        end
        expected_q.push_back(want);
        sent++;
      end
      if (s_axis_tvalid && !took) begin
        // hold the pending transaction
      end else if (gap_left != 0 || sent == stim_q.size()) begin
        s_axis_tvalid <= 1'b0;
        if (gap_left != 0) gap_left--;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(slc_pkg::IN_TDATA_W - slc_pkg::OP_W - slc_pkg::ADDR_W){1'b0}},
                          stim_q[sent].addr, stim_q[sent].op};
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 50);
          pick = $urandom_range(0, 9);
          gap_left = (pick < 4) ? 0 : (pick < 8) ? $urandom_range(1, 5) : $urandom_range(6, 20);
        end else burst_left--;
      end
    end

    // Drain outstanding results, then let the pipeline settle
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_q.size() != 0) report_mismatch("results left over, count", expected_q.size(), 0);

    if (error_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
